// File: rtl/pfenc_pkg.sv
// shared constants, types and helpers of the playfair pair encryptor
package pfenc_pkg;

   // key square geometry
   localparam int GRID_SIDE  = 6;
   localparam int GRID_CELLS = GRID_SIDE * GRID_SIDE;
   localparam int IDX_W      = $clog2(GRID_CELLS);
   localparam int POS_W      = $clog2(GRID_SIDE);
   localparam int SYM_W      = 8;

   // stream payload widths
   localparam int REQ_DATA_W = 32;
   localparam int RSP_DATA_W = 16;
   localparam int CIDX_W     = 6;

   // operation codes carried on req_tuser
   localparam logic OP_LOAD    = 1'b0;
   localparam logic OP_ENCRYPT = 1'b1;

   // status codes carried on rsp_tuser
   localparam logic STATUS_OK        = 1'b0;
   localparam logic STATUS_NOT_FOUND = 1'b1;

   typedef logic [SYM_W-1:0] sym_type;
   typedef logic [IDX_W-1:0] addr_type;
   typedef logic [POS_W-1:0] pos_type;

   // write port of the key store
   typedef struct packed {
      logic     en;
      addr_type addr;
      sym_type  data;
   } key_wr_type;

   // next row or column with wrap
   function automatic pos_type next_pos(input pos_type p);
      pos_type r;
      if (p == pos_type'(GRID_SIDE - 1)) begin
         r = '0;
      end else begin
         r = p + pos_type'(1);
      end
      return r;
   endfunction

   // row-major cell address of a row and column
   function automatic addr_type cell_addr(input pos_type row, input pos_type col);
      addr_type a;
      a = addr_type'(row) * addr_type'(GRID_SIDE) + addr_type'(col);
      return a;
   endfunction

endpackage

// File: rtl/pfenc_key_store.sv
// key square storage: one write port, one registered read port, per-cell valid bits
module pfenc_key_store (
   input  logic                clock,
   input  logic                reset,
   input  pfenc_pkg::key_wr_type wr,
   input  pfenc_pkg::addr_type rd_addr,
   output pfenc_pkg::sym_type  rd_data
);
   import pfenc_pkg::*;

   sym_type                 key_mem [GRID_CELLS];
   logic [GRID_CELLS-1:0]   cell_valid_ff;
   sym_type                 rd_data_ff;
   logic                    rd_valid_ff;

   // memory write
   always_ff @(posedge clock) begin
      if (wr.en) begin
         key_mem[wr.addr] <= wr.data;
      end
   end

   // valid bits, cleared by reset so unwritten cells read as zero
   always_ff @(posedge clock) begin
      if (reset) begin
         cell_valid_ff <= '0;
      end else if (wr.en) begin
         cell_valid_ff[wr.addr] <= 1'b1;
      end
   end

   // registered read
   always_ff @(posedge clock) begin
      rd_data_ff <= key_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_valid_ff <= 1'b0;
      end else begin
         rd_valid_ff <= cell_valid_ff[rd_addr];
      end
   end

   assign rd_data = rd_valid_ff ? rd_data_ff : '0;

endmodule

// File: rtl/playfair_6x6_pair_encrypt_unit.sv
// playfair 6x6 pair encryptor: sequencer scanning the key square through one read port
// load: no item out; an equal pair goes from ST_IDLE straight to ST_OUT; a missing symbol
// goes from ST_SCAN through ST_RESOLVE to ST_OUT; a normal pair adds ST_FETCH_A, B and W
// one encrypt item at a time: no new request is taken until ST_OUT hands the result over,
// which can wait on rsp_tready; the pace is set by the linear scan through the single read port
// reset: synchronous, active high; clears the sequencer, the output valid flag and
// the cell valid bits, so the whole key square reads as zero until loaded
module playfair_6x6_pair_encrypt_unit (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // [5:0] cell_index, [13:6] cell_symbol, [21:14] first_symbol,
   // [29:22] second_symbol, [31:30] zero
   input  logic [pfenc_pkg::REQ_DATA_W-1:0]   req_tdata,
   // [0] operation
   input  logic                               req_tuser,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // [7:0] cipher_first, [15:8] cipher_second
   output logic [pfenc_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   // [0] status
   output logic                               rsp_tuser
);
   import pfenc_pkg::*;

   typedef enum logic [6:0] {
      ST_IDLE    = 7'b0000001,
      ST_SCAN    = 7'b0000010,
      ST_RESOLVE = 7'b0000100,
      ST_FETCH_A = 7'b0001000,
      ST_FETCH_B = 7'b0010000,
      ST_FETCH_W = 7'b0100000,
      ST_OUT     = 7'b1000000
   } state_type;

   state_type state_ff, state_in;

   // request fields
   logic                req_operation;
   logic [CIDX_W-1:0]   req_cell_index;
   sym_type             req_cell_symbol;
   sym_type             req_first_symbol;
   sym_type             req_second_symbol;
   logic                req_accept;

   assign req_operation     = req_tuser;
   assign req_cell_index    = req_tdata[5:0];
   assign req_cell_symbol   = req_tdata[13:6];
   assign req_first_symbol  = req_tdata[21:14];
   assign req_second_symbol = req_tdata[29:22];

   // working registers
   sym_type  sym_a_ff, sym_a_in;
   sym_type  sym_b_ff, sym_b_in;
   addr_type iss_addr_ff, iss_addr_in;
   pos_type  iss_row_ff, iss_row_in;
   pos_type  iss_col_ff, iss_col_in;
   logic     iss_active_ff, iss_active_in;
   pos_type  cmp_row_ff, cmp_row_in;
   pos_type  cmp_col_ff, cmp_col_in;
   logic     cmp_live_ff, cmp_live_in;
   logic     cmp_last_ff, cmp_last_in;
   logic     found_a_ff, found_a_in;
   logic     found_b_ff, found_b_in;
   pos_type  a_row_ff, a_row_in;
   pos_type  a_col_ff, a_col_in;
   pos_type  b_row_ff, b_row_in;
   pos_type  b_col_ff, b_col_in;
   addr_type addr1_ff, addr1_in;
   addr_type addr2_ff, addr2_in;
   sym_type  res_first_ff, res_first_in;
   sym_type  res_second_ff, res_second_in;
   logic     res_status_ff, res_status_in;

   // output register
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0]   rsp_data_ff, rsp_data_in;
   logic                    rsp_status_ff, rsp_status_in;

   // key store ports
   key_wr_type key_wr;
   addr_type   rd_addr;
   sym_type    rd_data;

   pfenc_key_store u_key_store (
      .clock   (clock),
      .reset   (reset),
      .wr      (key_wr),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign req_accept = req_tvalid && req_tready;

   // load writes, out-of-range cells dropped
   always_comb begin
      key_wr.en   = req_accept && (req_operation == OP_LOAD) &&
                    ((9)'(req_cell_index) < (9)'(GRID_CELLS));
      key_wr.addr = addr_type'(req_cell_index);
      key_wr.data = req_cell_symbol;
   end

   // read address select
   always_comb begin
      case (state_ff)
         ST_FETCH_A: rd_addr = addr1_ff;
         ST_FETCH_B: rd_addr = addr2_ff;
         default:    rd_addr = iss_addr_ff;
      endcase
   end

   // sequencer
   always_comb begin
      pos_type r1, c1, r2, c2;

      state_in      = state_ff;
      sym_a_in      = sym_a_ff;
      sym_b_in      = sym_b_ff;
      iss_addr_in   = iss_addr_ff;
      iss_row_in    = iss_row_ff;
      iss_col_in    = iss_col_ff;
      iss_active_in = iss_active_ff;
      cmp_row_in    = cmp_row_ff;
      cmp_col_in    = cmp_col_ff;
      cmp_live_in   = 1'b0;
      cmp_last_in   = cmp_last_ff;
      found_a_in    = found_a_ff;
      found_b_in    = found_b_ff;
      a_row_in      = a_row_ff;
      a_col_in      = a_col_ff;
      b_row_in      = b_row_ff;
      b_col_in      = b_col_ff;
      addr1_in      = addr1_ff;
      addr2_in      = addr2_ff;
      res_first_in  = res_first_ff;
      res_second_in = res_second_ff;
      res_status_in = res_status_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_data_in   = rsp_data_ff;
      rsp_status_in = rsp_status_ff;

      r1 = a_row_ff;
      c1 = a_col_ff;
      r2 = b_row_ff;
      c2 = b_col_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_accept && (req_operation == OP_ENCRYPT)) begin
               sym_a_in = req_first_symbol;
               sym_b_in = req_second_symbol;
               if (req_first_symbol == req_second_symbol) begin
                  // equal pair passes through
                  res_first_in  = req_first_symbol;
                  res_second_in = req_second_symbol;
                  res_status_in = STATUS_OK;
                  state_in      = ST_OUT;
               end else begin
                  iss_addr_in   = '0;
                  iss_row_in    = '0;
                  iss_col_in    = '0;
                  iss_active_in = 1'b1;
                  cmp_last_in   = 1'b0;
                  found_a_in    = 1'b0;
                  found_b_in    = 1'b0;
                  state_in      = ST_SCAN;
               end
            end
         end

         ST_SCAN: begin
            // issue side: walk cells in row-major order
            if (iss_active_ff) begin
               cmp_live_in = 1'b1;
               cmp_row_in  = iss_row_ff;
               cmp_col_in  = iss_col_ff;
               cmp_last_in = (iss_addr_ff == addr_type'(GRID_CELLS - 1));
               if (iss_addr_ff == addr_type'(GRID_CELLS - 1)) begin
                  iss_active_in = 1'b0;
               end else begin
                  iss_addr_in = iss_addr_ff + addr_type'(1);
                  if (iss_col_ff == pos_type'(GRID_SIDE - 1)) begin
                     iss_col_in = '0;
                     iss_row_in = iss_row_ff + pos_type'(1);
                  end else begin
                     iss_col_in = iss_col_ff + pos_type'(1);
                  end
               end
            end
            // compare side: keep the first match of each symbol
            if (cmp_live_ff) begin
               if (!found_a_ff && (rd_data == sym_a_ff)) begin
                  found_a_in = 1'b1;
                  a_row_in   = cmp_row_ff;
                  a_col_in   = cmp_col_ff;
               end
               if (!found_b_ff && (rd_data == sym_b_ff)) begin
                  found_b_in = 1'b1;
                  b_row_in   = cmp_row_ff;
                  b_col_in   = cmp_col_ff;
               end
               if (cmp_last_ff) begin
                  state_in = ST_RESOLVE;
               end
            end
         end

         ST_RESOLVE: begin
            if (!(found_a_ff && found_b_ff)) begin
               res_first_in  = '0;
               res_second_in = '0;
               res_status_in = STATUS_NOT_FOUND;
               state_in      = ST_OUT;
            end else begin
               // playfair rule: same row, same column, or rectangle
               if (a_row_ff == b_row_ff) begin
                  c1 = next_pos(a_col_ff);
                  c2 = next_pos(b_col_ff);
               end else if (a_col_ff == b_col_ff) begin
                  r1 = next_pos(a_row_ff);
                  r2 = next_pos(b_row_ff);
               end else begin
                  c1 = b_col_ff;
                  c2 = a_col_ff;
               end
               addr1_in      = cell_addr(r1, c1);
               addr2_in      = cell_addr(r2, c2);
               res_status_in = STATUS_OK;
               state_in      = ST_FETCH_A;
            end
         end

         ST_FETCH_A: begin
            state_in = ST_FETCH_B;
         end

         ST_FETCH_B: begin
            res_first_in = rd_data;
            state_in     = ST_FETCH_W;
         end

         ST_FETCH_W: begin
            res_second_in = rd_data;
            state_in      = ST_OUT;
         end

         ST_OUT: begin
            // hand over once the output register is free
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in  = 1'b1;
               rsp_data_in   = {res_second_ff, res_first_ff};
               rsp_status_in = res_status_ff;
               state_in      = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         iss_active_ff <= 1'b0;
         cmp_live_ff   <= 1'b0;
         cmp_last_ff   <= 1'b0;
         found_a_ff    <= 1'b0;
         found_b_ff    <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         iss_active_ff <= iss_active_in;
         cmp_live_ff   <= cmp_live_in;
         cmp_last_ff   <= cmp_last_in;
         found_a_ff    <= found_a_in;
         found_b_ff    <= found_b_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      sym_a_ff      <= sym_a_in;
      sym_b_ff      <= sym_b_in;
      iss_addr_ff   <= iss_addr_in;
      iss_row_ff    <= iss_row_in;
      iss_col_ff    <= iss_col_in;
      cmp_row_ff    <= cmp_row_in;
      cmp_col_ff    <= cmp_col_in;
      a_row_ff      <= a_row_in;
      a_col_ff      <= a_col_in;
      b_row_ff      <= b_row_in;
      b_col_ff      <= b_col_in;
      addr1_ff      <= addr1_in;
      addr2_ff      <= addr2_in;
      res_first_ff  <= res_first_in;
      res_second_ff <= res_second_in;
      res_status_ff <= res_status_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_status_ff;

   // a not-found result carries zero symbols
   a_not_found_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tuser == STATUS_NOT_FOUND)) |-> (rsp_tdata == '0))
      else $error("not-found result with nonzero symbols");

   // an unequal encrypt pair starts the scan at cell zero
   a_scan_start: assert property (@(posedge clock) disable iff (reset)
      (req_accept && (req_operation == OP_ENCRYPT) &&
       (req_first_symbol != req_second_symbol))
      |=> (state_ff == ST_SCAN) && (iss_addr_ff == '0) && !found_a_ff && !found_b_ff)
      else $error("scan did not start cleanly");

   // the scan ends after the compare of the last cell
   a_scan_end: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_SCAN) && cmp_live_ff && cmp_last_ff) |=> (state_ff == ST_RESOLVE))
      else $error("scan did not end at the last cell");

   // a missing symbol goes straight to the result with error status
   a_missing_symbol: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_RESOLVE) && !(found_a_ff && found_b_ff))
      |=> (state_ff == ST_OUT) && (res_status_ff == STATUS_NOT_FOUND))
      else $error("missing symbol not reported");

   // no new item while the sequencer is busy
   a_busy_no_accept: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> !req_tready)
      else $error("item accepted while busy");

endmodule
